// File: design/slmfs_pkg.sv
// Shared types and constants for the serpentine LED matrix frame store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package slmfs_pkg;

  localparam int ROWS_DEF     = 8;
  localparam int ROW_LEDS_DEF = 16;

  localparam int OP_W        = 2;
  localparam int ROW_FIELD_W = 3;
  localparam int ROW_BITS_W  = 16;
  localparam int COLOUR_W    = 2;
  localparam int PIX_W       = 2;
  localparam int LED_WORD_W  = 24;
  localparam int CFG_IDX_W   = 1;

  localparam logic [LED_WORD_W-1:0] COLOUR_ONE_RST = 24'd15;
  localparam logic [LED_WORD_W-1:0] COLOUR_TWO_RST = 24'd771;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_TWO = 1'b1;

  // stored colour indexes; index 3 also shows dark
  localparam logic [PIX_W-1:0] PIX_DARK = 2'd0;
  localparam logic [PIX_W-1:0] PIX_ONE  = 2'd1;
  localparam logic [PIX_W-1:0] PIX_TWO  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_FACE = 2'd0,
    OP_MASK = 2'd1,
    OP_SEND = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MASK = 3'b010,
    ST_SEND = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: design/slmfs_row_mem.sv
// Row-wide pixel memory: one entry per matrix row, registered read port.
// Per-row valid flops make unwritten rows read as dark. Uses slmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slmfs_row_mem
  import slmfs_pkg::*;
#(
  parameter int ROWS  = ROWS_DEF,
  parameter int ROW_W = ROW_LEDS_DEF * PIX_W,
  parameter int AW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [ROW_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  valid_r;
  logic [ROW_W-1:0] q_r;
  logic             q_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = q_valid_r ? q_r : '0;

endmodule

`default_nettype wire

// File: design/slmfs_row_merge.sv
// Builds the new contents of a row from item bits, with serpentine mirroring
// on odd rows: face load replaces, mask overlay merges. Uses slmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slmfs_row_merge
  import slmfs_pkg::*;
#(
  parameter int ROW_LEDS = ROW_LEDS_DEF
) (
  input  wire logic                      face,
  input  wire logic                      odd,
  input  wire logic [ROW_BITS_W-1:0]     row_bits,
  input  wire logic [COLOUR_W-1:0]       colour,
  input  wire logic [ROW_LEDS*PIX_W-1:0] old_row,
  output logic      [ROW_LEDS*PIX_W-1:0] new_row
);

  logic [ROW_LEDS-1:0] bit_even;
  logic [ROW_LEDS-1:0] bit_odd;
  logic [ROW_LEDS-1:0] pbit;

  for (genvar j = 0; j < ROW_LEDS; j++) begin : g_pix
    // bits past the row_bits field read as zero
    if (j < ROW_BITS_W) begin : g_even
      assign bit_even[j] = row_bits[j];
    end else begin : g_even_z
      assign bit_even[j] = 1'b0;
    end
    if (ROW_LEDS - 1 - j < ROW_BITS_W) begin : g_odd
      assign bit_odd[j] = row_bits[ROW_LEDS-1-j];
    end else begin : g_odd_z
      assign bit_odd[j] = 1'b0;
    end
    assign pbit[j] = odd ? bit_odd[j] : bit_even[j];

    assign new_row[j*PIX_W +: PIX_W] = face    ? (pbit[j] ? PIX_ONE : PIX_DARK) :
                                       pbit[j] ? PIX_W'(colour) :
                                                 old_row[j*PIX_W +: PIX_W];
  end

endmodule

`default_nettype wire

// File: design/serpentine_led_matrix_frame_store_top.sv
// Top level of the serpentine LED matrix frame store: control sequencer,
// colour registers and output stage. Uses slmfs_pkg, slmfs_row_mem, slmfs_row_merge.
//
//  port group | direction | handshake                | payload
//  in_        | in        | start high, busy low     | in_op, in_row, in_row_bits, in_colour
//  out_       | out       | out_valid, one cycle     | out_led_word, out_last, out_frame_end
//  cfg_       | in        | cfg_we, no wait          | cfg_index, cfg_wdata
//
// Face load: written straight into the row memory; busy stays low.
// Mask overlay: read of the row, then modify and write back from ST_MASK.
// Send: busy while the row is sent; words leave one per cycle after the
// registered memory read and the registered output stage.
// Reset clears per-row valid flags at once; no clearing pass is needed.
// The receiver cannot stall, so results never wait.
`timescale 1ns / 1ps
`default_nettype none

module serpentine_led_matrix_frame_store_top
  import slmfs_pkg::*;
#(
  parameter int ROWS     = ROWS_DEF,
  parameter int ROW_LEDS = ROW_LEDS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [OP_W-1:0]        in_op,
  input  wire logic [ROW_FIELD_W-1:0] in_row,
  input  wire logic [ROW_BITS_W-1:0]  in_row_bits,
  input  wire logic [COLOUR_W-1:0]    in_colour,
  output logic                        out_valid,
  output logic      [LED_WORD_W-1:0]  out_led_word,
  output logic                        out_last,
  output logic                        out_frame_end,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [LED_WORD_W-1:0]  cfg_wdata
);

  localparam int AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW       = (ROW_LEDS > 1) ? $clog2(ROW_LEDS) : 1;
  localparam int ROW_W    = ROW_LEDS * PIX_W;
  localparam int LAST_ROW = ROWS - 1;
  localparam int LAST_PIX = ROW_LEDS - 1;

  state_t                  state_r, state_nxt;
  logic [ROW_FIELD_W-1:0]  row_r, row_nxt;
  logic [ROW_BITS_W-1:0]   bits_r, bits_nxt;
  logic [COLOUR_W-1:0]     colour_r, colour_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [LED_WORD_W-1:0]   colour_one_word_r, colour_two_word_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [LED_WORD_W-1:0]   out_led_word_r, out_led_word_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_frame_end_r, out_frame_end_nxt;

  logic                    acc;
  logic                    row_ok;
  logic                    mem_wr_en;
  logic [AW-1:0]           mem_wr_addr;
  logic                    mem_rd_en;
  logic [ROW_W-1:0]        mem_rd_data;
  logic [ROW_W-1:0]        merged_row;
  logic                    mg_face;
  logic                    mg_odd;
  logic [ROW_BITS_W-1:0]   mg_bits;
  logic [COLOUR_W-1:0]     mg_colour;
  logic [PIX_W-1:0]        pix;
  logic                    pix_last;

  assign busy   = (state_r != ST_IDLE);
  assign acc    = start && !busy;
  assign row_ok = (32'(in_row) < 32'(ROWS));

  // face load uses the live item, mask write-back the held one
  assign mg_face   = (state_r == ST_IDLE);
  assign mg_odd    = mg_face ? in_row[0] : row_r[0];
  assign mg_bits   = mg_face ? in_row_bits : bits_r;
  assign mg_colour = mg_face ? in_colour : colour_r;

  assign mem_wr_en = (acc && row_ok && (in_op == OP_FACE)) || (state_r == ST_MASK);
  assign mem_wr_addr = (state_r == ST_MASK) ? AW'(row_r) : AW'(in_row);
  assign mem_rd_en = acc && row_ok && ((in_op == OP_MASK) || (in_op == OP_SEND));

  slmfs_row_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (merged_row),
    .rd_en   (mem_rd_en),
    .rd_addr (AW'(in_row)),
    .rd_data (mem_rd_data)
  );

  slmfs_row_merge #(
    .ROW_LEDS (ROW_LEDS)
  ) u_row_merge (
    .face     (mg_face),
    .odd      (mg_odd),
    .row_bits (mg_bits),
    .colour   (mg_colour),
    .old_row  (mem_rd_data),
    .new_row  (merged_row)
  );

  assign pix      = mem_rd_data[cnt_r*PIX_W +: PIX_W];
  assign pix_last = (cnt_r == CW'(LAST_PIX));

  always_comb begin
    state_nxt         = state_r;
    row_nxt           = row_r;
    bits_nxt          = bits_r;
    colour_nxt        = colour_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = 1'b0;
    out_led_word_nxt  = out_led_word_r;
    out_last_nxt      = 1'b0;
    out_frame_end_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          row_nxt    = in_row;
          bits_nxt   = in_row_bits;
          colour_nxt = in_colour;
          cnt_nxt    = '0;
          if (row_ok && (in_op == OP_MASK)) begin
            state_nxt = ST_MASK;
          end else if (row_ok && (in_op == OP_SEND)) begin
            state_nxt = ST_SEND;
          end
        end
      end
      ST_MASK: begin
        state_nxt = ST_IDLE;
      end
      ST_SEND: begin
        out_valid_nxt = 1'b1;
        case (pix)
          PIX_ONE: out_led_word_nxt = colour_one_word_r;
          PIX_TWO: out_led_word_nxt = colour_two_word_r;
          default: out_led_word_nxt = '0;
        endcase
        out_last_nxt      = pix_last;
        out_frame_end_nxt = pix_last && (32'(row_r) == 32'(LAST_ROW));
        if (pix_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      cnt_r             <= '0;
      out_valid_r       <= 1'b0;
      out_last_r        <= 1'b0;
      out_frame_end_r   <= 1'b0;
      colour_one_word_r <= COLOUR_ONE_RST;
      colour_two_word_r <= COLOUR_TWO_RST;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      out_valid_r     <= out_valid_nxt;
      out_last_r      <= out_last_nxt;
      out_frame_end_r <= out_frame_end_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLOUR_ONE: colour_one_word_r <= cfg_wdata;
          CFG_COLOUR_TWO: colour_two_word_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // item payload and output word: no reset
  always_ff @(posedge clk) begin
    row_r          <= row_nxt;
    bits_r         <= bits_nxt;
    colour_r       <= colour_nxt;
    out_led_word_r <= out_led_word_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_led_word  = out_led_word_r;
  assign out_last      = out_last_r;
  assign out_frame_end = out_frame_end_r;

  a_out_from_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SEND))
    else $error("result strobe without a send cycle");

  a_send_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && row_ok && (in_op == OP_SEND)) |=> (state_r == ST_SEND) && (cnt_r == '0))
    else $error("accepted send did not start its run");

  a_mask_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MASK) |=> (state_r == ST_IDLE))
    else $error("mask write-back held more than one cycle");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_end |-> (out_last && out_valid))
    else $error("frame end flagged away from the last word");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for serpentine_led_matrix_frame_store_top.
// Depends on slmfs_pkg and the design files; a scoreboard class predicts the LED words.
`timescale 1ns / 1ps

module tb_top;
  import slmfs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [ROW_FIELD_W-1:0] LAST_ROW = ROW_FIELD_W'(ROWS_DEF - 1);
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 96;

  typedef struct packed {
    logic [LED_WORD_W-1:0] led_word;
    logic                  last;
    logic                  frame_end;
  } led_result_t;

  class led_frame_model;
    logic [PIX_W-1:0] pixels [ROWS_DEF][ROW_LEDS_DEF];
    logic [LED_WORD_W-1:0] colour_one;
    logic [LED_WORD_W-1:0] colour_two;
    led_result_t pending_words [$];
    int mismatches;
    int words_checked;

    function new();
      colour_one = COLOUR_ONE_RST;
      colour_two = COLOUR_TWO_RST;
      foreach (pixels[r, j]) pixels[r][j] = PIX_DARK;
      mismatches = 0;
      words_checked = 0;
    endfunction

    function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [LED_WORD_W-1:0] val);
      if (idx == CFG_COLOUR_ONE) colour_one = val;
      else colour_two = val;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [ROW_FIELD_W-1:0] row,
                            logic [ROW_BITS_W-1:0] bits, logic [COLOUR_W-1:0] colour);
      logic b;
      led_result_t res;
      for (int j = 0; j < ROW_LEDS_DEF; j++) begin
        // odd strips run the other way: mirror the row bits
        b = row[0] ? bits[ROW_LEDS_DEF-1-j] : bits[j];
        case (op)
          OP_FACE: pixels[row][j] = b ? PIX_ONE : PIX_DARK;
          OP_MASK: if (b) pixels[row][j] = colour;
          OP_SEND: begin
            if (pixels[row][j] == PIX_ONE) res.led_word = colour_one;
            else if (pixels[row][j] == PIX_TWO) res.led_word = colour_two;
            else res.led_word = '0;
            res.last = (j == ROW_LEDS_DEF - 1);
            res.frame_end = res.last && (row == LAST_ROW);
            pending_words.push_back(res);
          end
          default: ;
        endcase
      end
    endfunction

    function void check_word(logic [LED_WORD_W-1:0] word, logic last, logic frame_end);
      led_result_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected LED word %h (last %b, frame_end %b)", word, last, frame_end);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (word !== want.led_word) begin
        $error("led_word: expected %h, got %h", want.led_word, word);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, got %b", want.last, last);
        mismatches++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [OP_W-1:0] in_op;
  logic [ROW_FIELD_W-1:0] in_row;
  logic [ROW_BITS_W-1:0] in_row_bits;
  logic [COLOUR_W-1:0] in_colour;
  logic out_valid;
  logic [LED_WORD_W-1:0] out_led_word;
  logic out_last;
  logic out_frame_end;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LED_WORD_W-1:0] cfg_wdata;

  led_frame_model model = new();
  int op_count [4];
  int cfg_writes;
  int cycle_count;

  serpentine_led_matrix_frame_store_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_row       (in_row),
    .in_row_bits  (in_row_bits),
    .in_colour    (in_colour),
    .out_valid    (out_valid),
    .out_led_word (out_led_word),
    .out_last     (out_last),
    .out_frame_end(out_frame_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) model.check_word(out_led_word, out_last, out_frame_end);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out with %0d LED words outstanding", model.pending_words.size());
      $display("status: fail");
      $finish;
    end
  end

  // hold the item until busy is low at an edge
  task automatic issue_item(logic [OP_W-1:0] op, logic [ROW_FIELD_W-1:0] row,
                            logic [ROW_BITS_W-1:0] bits, logic [COLOUR_W-1:0] colour);
    start       <= 1'b1;
    in_op       <= op;
    in_row      <= row;
    in_row_bits <= bits;
    in_colour   <= colour;
    do @(posedge clk); while (busy);
    model.note_item(op, row, bits, colour);
    op_count[op]++;
  endtask

  task automatic rest_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drain all words and let any overlay finish before touching a colour register
  task automatic write_colour(logic [CFG_IDX_W-1:0] idx, logic [LED_WORD_W-1:0] val);
    start <= 1'b0;
    while (model.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    model.set_colour(idx, val);
    cfg_writes++;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ROW_BITS_W-1:0] pick_row_bits();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return ROW_BITS_W'(1) << $urandom_range(0, ROW_BITS_W - 1);
      default: return ROW_BITS_W'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 5) op = OP_UNUSED;
    else if (pick < 35) op = OP_FACE;
    else if (pick < 65) op = OP_MASK;
    else op = OP_SEND;
    issue_item(op, ROW_FIELD_W'($urandom_range(0, ROWS_DEF - 1)), pick_row_bits(),
               COLOUR_W'($urandom_range(0, 3)));
  endtask

  initial begin
    logic idling;
    int accepted;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_op       <= OP_FACE;
    in_row      <= '0;
    in_row_bits <= '0;
    in_colour   <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_COLOUR_ONE;
    cfg_wdata   <= '0;
    cycle_count <= 0;
    cfg_writes = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset colour words
    issue_item(OP_SEND, 3'd0, 16'h0000, 2'd0);
    issue_item(OP_SEND, LAST_ROW, 16'h0000, 2'd0);
    issue_item(OP_FACE, 3'd0, 16'hFFFF, 2'd0);
    issue_item(OP_FACE, 3'd1, 16'h0001, 2'd0);
    issue_item(OP_FACE, LAST_ROW, 16'h8001, 2'd3);
    issue_item(OP_SEND, 3'd0, 16'h0000, 2'd0);
    issue_item(OP_SEND, 3'd1, 16'hFFFF, 2'd3);
    issue_item(OP_SEND, LAST_ROW, 16'h0000, 2'd0);
    issue_item(OP_MASK, 3'd1, 16'h00F0, 2'd2);
    issue_item(OP_MASK, 3'd2, 16'hFFFF, 2'd3);
    issue_item(OP_FACE, 3'd3, 16'hFFFF, 2'd0);
    issue_item(OP_MASK, 3'd3, 16'hAAAA, 2'd0);
    issue_item(OP_MASK, 3'd4, 16'h5555, 2'd1);
    issue_item(OP_UNUSED, 3'd0, 16'hFFFF, 2'd3);
    issue_item(OP_SEND, 3'd1, 16'h0000, 2'd0);
    issue_item(OP_SEND, 3'd2, 16'h0000, 2'd0);
    issue_item(OP_SEND, 3'd3, 16'h0000, 2'd0);
    issue_item(OP_SEND, 3'd4, 16'h0000, 2'd0);
    issue_item(OP_FACE, 3'd6, 16'h0000, 2'd0);
    issue_item(OP_MASK, 3'd6, 16'hFFFF, 2'd2);
    issue_item(OP_SEND, 3'd6, 16'h0000, 2'd0);
    issue_item(OP_MASK, 3'd5, 16'h8000, 2'd2);
    issue_item(OP_SEND, 3'd5, 16'h0000, 2'd0);
    issue_item(OP_FACE, 3'd0, 16'h1234, 2'd1);
    issue_item(OP_SEND, 3'd0, 16'h0000, 2'd0);

    // random part: one colour setting per phase, extremes in two of them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_colour(CFG_COLOUR_ONE, '1);
          write_colour(CFG_COLOUR_TWO, '0);
        end
        2: begin
          write_colour(CFG_COLOUR_ONE, '0);
          write_colour(CFG_COLOUR_TWO, '1);
        end
        default: begin
          write_colour(CFG_COLOUR_ONE, LED_WORD_W'($urandom));
          write_colour(CFG_COLOUR_TWO, LED_WORD_W'($urandom));
        end
      endcase
      accepted = 0;
      while (accepted < PHASE_ITEMS) begin
        // idle in bursts, with quiet stretches; none in the final phase
        idling = (phase < 3) && ((accepted % 32) < 20);
        if (idling && $urandom_range(0, 2) == 0) rest_cycles($urandom_range(1, 12));
        random_item();
        if (in_op != OP_UNUSED) accepted++;
      end
    end

    start <= 1'b0;
    while (model.pending_words.size() != 0) @(posedge clk);
    repeat (2 * ROW_LEDS_DEF) @(posedge clk);

    $display("%0d face, %0d mask, %0d send and %0d unused-op items; %0d LED words checked",
             op_count[OP_FACE], op_count[OP_MASK], op_count[OP_SEND], op_count[OP_UNUSED],
             model.words_checked);
    $display("%0d colour register writes across reset, all-zero, all-one and random words",
             cfg_writes);
    if (model.mismatches == 0 && model.pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/slmfs_pkg.sv
design/slmfs_row_mem.sv
design/slmfs_row_merge.sv
design/serpentine_led_matrix_frame_store_top.sv
tb/tb_top.sv
